[hw/rtl/rbf_pkg.sv]
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types and fixed field widths for the record byte fifo with block
// drain: request modes, result status codes and the control state type.
// ----------------------------------------------------------------------------
package rbf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int RMAX_W = 7;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 3;
    localparam int MODE_W = 3;
    localparam int LVL_W  = 10;
    localparam int WIDE_W = 17;
    localparam int MAX_READ = 64;

    // request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 3'd0,
        MODE_READ  = 3'd1,
        MODE_START = 3'd2,
        MODE_DONE  = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_BADLEN  = 3'd2,
        STAT_EMPTY   = 3'd3,
        STAT_BUSY    = 3'd4,
        STAT_REFUSED = 3'd5
    } status_t;

    // control sequencer states
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_DRAIN = 1'b1
    } fsm_t;

endpackage

[hw/rtl/rbf_store.sv]
// ----------------------------------------------------------------------------
// rbf_store
// Byte ring storage: one write port, one read port, registered read data
// that holds its value until the next read.
// ----------------------------------------------------------------------------
module rbf_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [rbf_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [rbf_pkg::BYTE_W-1:0] rd_data
);
    import rbf_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/rbf_ctrl.sv]
// ----------------------------------------------------------------------------
// rbf_ctrl
// Request sequencer: pointer and record tracking, single-result requests,
// byte-by-byte drain of reads and block starts from the store, and the
// output register.
// ----------------------------------------------------------------------------
module rbf_ctrl #(
    parameter int BUFFER_BYTES = 1024,
    parameter int MAX_BLOCK    = 64,
    parameter int PTR_W        = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request side
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rbf_pkg::MODE_W-1:0]  s_mode,
    input  logic [rbf_pkg::BYTE_W-1:0]  s_in_byte,
    input  logic                        s_record_first,
    input  logic [rbf_pkg::LEN_W-1:0]   s_record_len,
    input  logic [rbf_pkg::RMAX_W-1:0]  s_read_max,
    input  logic                        s_sender_accepts,
    // result side
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rbf_pkg::STAT_W-1:0]  m_status,
    output logic [rbf_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_byte_valid,
    output logic                        m_last,
    output logic [rbf_pkg::LVL_W-1:0]   m_fill_level,
    output logic [rbf_pkg::LVL_W-1:0]   m_free_bytes,
    output logic                        m_busy_res,
    // store ports
    output logic                        wr_en,
    output logic [PTR_W-1:0]            wr_addr,
    output logic [rbf_pkg::BYTE_W-1:0]  wr_data,
    output logic                        rd_en,
    output logic [PTR_W-1:0]            rd_addr,
    input  logic [rbf_pkg::BYTE_W-1:0]  rd_data
);
    import rbf_pkg::*;

    localparam logic [WIDE_W-1:0] BUF_W   = WIDE_W'(BUFFER_BYTES);
    localparam logic [WIDE_W-1:0] BLOCK_W = WIDE_W'(MAX_BLOCK);
    localparam logic [WIDE_W-1:0] READ_W  = WIDE_W'(MAX_READ);

    fsm_t               state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic               busy_reg, busy_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic               drop_reg, drop_next;
    logic [PTR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]   rd_left_reg, rd_left_next;
    logic               rd_pending_reg, rd_pending_next;

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg;
    logic [BYTE_W-1:0]  m_byte_reg;
    logic               m_bvalid_reg;
    logic               m_last_reg;
    logic [LVL_W-1:0]   m_fill_reg;
    logic [LVL_W-1:0]   m_free_reg;
    logic               m_busy_reg;

    logic               out_free;
    logic               s_fire;
    logic               single_load;
    status_t            single_status;
    logic               byte_load;

    logic [WIDE_W-1:0]  lvl_cur, free_cur, lvl_nxt, free_nxt;
    logic [WIDE_W-1:0]  rmax_cap, read_n, run_raw, run_n;
    logic [CNT_W-1:0]   read_cnt, run_cnt;

    // ring helpers
    function automatic logic [WIDE_W-1:0] level_of(input logic [PTR_W-1:0] w,
                                                   input logic [PTR_W-1:0] r);
        logic [WIDE_W-1:0] lv;
        if (w >= r) begin
            lv = WIDE_W'(w) - WIDE_W'(r);
        end else begin
            lv = WIDE_W'(w) + BUF_W - WIDE_W'(r);
        end
        return lv;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (WIDE_W'(p) == BUF_W - WIDE_W'(1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [WIDE_W-1:0] sum;
        sum = WIDE_W'(p) + WIDE_W'(n);
        if (sum >= BUF_W) begin
            sum = sum - BUF_W;
        end
        return sum[PTR_W-1:0];
    endfunction

    // current occupancy and burst sizes
    always_comb begin
        lvl_cur  = level_of(wp_reg, rp_reg);
        free_cur = BUF_W - lvl_cur - WIDE_W'(1);
        rmax_cap = (WIDE_W'(s_read_max) > READ_W) ? READ_W : WIDE_W'(s_read_max);
        read_n   = (rmax_cap > lvl_cur) ? lvl_cur : rmax_cap;
        read_cnt = read_n[CNT_W-1:0];
        if (wp_reg > rp_reg) begin
            run_raw = WIDE_W'(wp_reg) - WIDE_W'(rp_reg);
        end else begin
            run_raw = BUF_W - WIDE_W'(rp_reg);
        end
        run_n   = (run_raw > BLOCK_W) ? BLOCK_W : run_raw;
        run_cnt = run_n[CNT_W-1:0];
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    assign wr_addr = wp_reg;
    assign wr_data = s_in_byte;
    assign rd_addr = rd_addr_reg;

    // request sequencing
    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        busy_next       = busy_reg;
        left_next       = left_reg;
        drop_next       = drop_reg;
        rd_addr_next    = rd_addr_reg;
        rd_left_next    = rd_left_reg;
        rd_pending_next = rd_pending_reg;
        single_load     = 1'b0;
        single_status   = STAT_OK;
        byte_load       = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    single_load = 1'b1;
                    case (mode_t'(s_mode))
                        MODE_WRITE: begin
                            if (s_record_first) begin
                                left_next = '0;
                                drop_next = 1'b0;
                                if (s_record_len == '0) begin
                                    single_status = STAT_BADLEN;
                                end else begin
                                    left_next = s_record_len - LEN_W'(1);
                                    if (WIDE_W'(s_record_len) > free_cur) begin
                                        drop_next     = 1'b1;
                                        single_status = STAT_FULL;
                                    end else begin
                                        wr_en = 1'b1;
                                    end
                                end
                            end else if (left_reg == '0) begin
                                single_status = STAT_BADLEN;
                            end else begin
                                left_next = left_reg - LEN_W'(1);
                                if (drop_reg || free_cur == '0) begin
                                    single_status = STAT_FULL;
                                end else begin
                                    wr_en = 1'b1;
                                end
                            end
                            if (wr_en) begin
                                wp_next = ptr_inc(wp_reg);
                            end
                        end
                        MODE_READ: begin
                            if (lvl_cur == '0) begin
                                single_status = STAT_EMPTY;
                            end else if (read_cnt != '0) begin
                                single_load  = 1'b0;
                                rp_next      = ptr_add(rp_reg, read_cnt);
                                rd_addr_next = rp_reg;
                                rd_left_next = read_cnt;
                                state_next   = S_DRAIN;
                            end
                        end
                        MODE_START: begin
                            if (busy_reg) begin
                                single_status = STAT_BUSY;
                            end else if (lvl_cur == '0) begin
                                single_status = STAT_EMPTY;
                            end else if (!s_sender_accepts) begin
                                single_status = STAT_REFUSED;
                            end else begin
                                single_load  = 1'b0;
                                busy_next    = 1'b1;
                                rp_next      = ptr_add(rp_reg, run_cnt);
                                rd_addr_next = rp_reg;
                                rd_left_next = run_cnt;
                                state_next   = S_DRAIN;
                            end
                        end
                        MODE_DONE: begin
                            busy_next = 1'b0;
                        end
                        MODE_CLEAR: begin
                            wp_next = '0;
                            rp_next = '0;
                        end
                        default: begin
                            single_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                // one store read a cycle, issued as the previous byte moves out
                byte_load = rd_pending_reg && out_free;
                rd_en     = (rd_left_reg != '0) && (!rd_pending_reg || byte_load);
                if (rd_en) begin
                    rd_addr_next    = ptr_inc(rd_addr_reg);
                    rd_left_next    = rd_left_reg - CNT_W'(1);
                    rd_pending_next = 1'b1;
                end else if (byte_load) begin
                    rd_pending_next = 1'b0;
                end
                if (byte_load && rd_left_reg == '0) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // occupancy after this request, reported with every result
    always_comb begin
        lvl_nxt  = level_of(wp_next, rp_next);
        free_nxt = BUF_W - lvl_nxt - WIDE_W'(1);
    end

    assign m_valid_next = (single_load || byte_load) ? 1'b1 :
                          (m_ready ? 1'b0 : m_valid_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            busy_reg       <= 1'b0;
            left_reg       <= '0;
            drop_reg       <= 1'b0;
            rd_left_reg    <= '0;
            rd_pending_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            busy_reg       <= busy_next;
            left_reg       <= left_next;
            drop_reg       <= drop_next;
            rd_left_reg    <= rd_left_next;
            rd_pending_reg <= rd_pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // drain read address
    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (single_load || byte_load) begin
            m_status_reg <= byte_load ? STAT_OK : single_status;
            m_byte_reg   <= byte_load ? rd_data : '0;
            m_bvalid_reg <= byte_load;
            m_last_reg   <= byte_load ? (rd_left_reg == '0) : 1'b1;
            m_fill_reg   <= lvl_nxt[LVL_W-1:0];
            m_free_reg   <= free_nxt[LVL_W-1:0];
            m_busy_reg   <= busy_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_byte_valid = m_bvalid_reg;
    assign m_last       = m_last_reg;
    assign m_fill_level = m_fill_reg;
    assign m_free_bytes = m_free_reg;
    assign m_busy_res   = m_busy_reg;

`ifndef ASSERT_OFF
    // a pending store read exists only while draining
    a_pending_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pending_reg |-> (state_reg == S_DRAIN))
        else $error("read pending outside drain");

    // every issued read is waiting for the output on the next cycle
    a_read_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> rd_pending_reg)
        else $error("issued read lost");

    // pointers stay inside the ring
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (WIDE_W'(wp_reg) < BUF_W) && (WIDE_W'(rp_reg) < BUF_W))
        else $error("pointer out of range");

    // no writes and no pointer moves while a drain runs
    a_drain_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN) |=> ($stable(wp_reg) && $stable(rp_reg)))
        else $error("pointers moved during drain");
`endif

endmodule

[hw/rtl/record_byte_fifo_with_block_drain_core.sv]
// ----------------------------------------------------------------------------
// record_byte_fifo_with_block_drain_core
// Byte ring fifo with record admission, bounded reads and block drain.
// ----------------------------------------------------------------------------
// One request enters per cycle while no drain runs and the output register is
// free or being taken; a request with a single result (write, refused read or
// start, transmit complete, clear, unused mode) loads its result as it is accepted. A read of
// n bytes or a block start that drains n bytes holds the request side until its
// last byte is in the output register; the store's read port gives one byte per
// cycle while the output register can take it, each through its read register.
// The store keeps one slot empty and holds up to BUFFER_BYTES - 1 bytes; it needs
// no clearing after reset, since only written entries are ever read.
module record_byte_fifo_with_block_drain_core #(
    parameter int BUFFER_BYTES = 1024,
    parameter int MAX_BLOCK    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // in_byte, record_first, record_len, read_max, sender_accepts
    input  logic [2:0]  s_tuser,  // mode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // out_byte, fill_level, free_bytes, busy_res
    output logic [3:0]  m_tuser,  // status, byte_valid
    output logic        m_tlast
);
    import rbf_pkg::*;

    localparam int PTR_W = $clog2(BUFFER_BYTES);

    logic                wr_en, rd_en;
    logic [PTR_W-1:0]    wr_addr, rd_addr;
    logic [BYTE_W-1:0]   wr_data, rd_data;

    logic [STAT_W-1:0]   status;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic [LVL_W-1:0]    fill_level, free_bytes;
    logic                busy_res;

    // byte storage
    rbf_store #(
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (PTR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sequencer and output register
    rbf_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_BLOCK    (MAX_BLOCK),
        .PTR_W        (PTR_W)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_tvalid),
        .s_ready          (s_tready),
        .s_mode           (s_tuser[2:0]),
        .s_in_byte        (s_tdata[7:0]),
        .s_record_first   (s_tdata[8]),
        .s_record_len     (s_tdata[18:9]),
        .s_read_max       (s_tdata[25:19]),
        .s_sender_accepts (s_tdata[26]),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_status         (status),
        .m_out_byte       (out_byte),
        .m_byte_valid     (byte_valid),
        .m_last           (m_tlast),
        .m_fill_level     (fill_level),
        .m_free_bytes     (free_bytes),
        .m_busy_res       (busy_res),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data)
    );

    // result packing
    assign m_tdata = {3'b000, busy_res, free_bytes, fill_level, out_byte};
    assign m_tuser = {byte_valid, status};

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record byte fifo with block drain. Requests are
// queued up front, sent in random bursts and mirrored into a behavioral ring
// model on acceptance. Every result beat is compared field by field against
// the oldest predicted beat while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;

    import rbf_pkg::*;

    localparam int RING_BYTES    = 1024;
    localparam int BLOCK_BYTES   = 64;
    localparam int RANDOM_ITEMS  = 240;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // one request as the bench sees it
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] data;
        logic              first;
        logic [LEN_W-1:0]  len;
        logic [RMAX_W-1:0] rmax;
        logic              accepts;
    } fifo_req_t;

    // one result beat
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
        logic [LVL_W-1:0]  level;
        logic [LVL_W-1:0]  room;
        logic              busy;
    } fifo_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    record_byte_fifo_with_block_drain_core #(
        .BUFFER_BYTES(RING_BYTES),
        .MAX_BLOCK(BLOCK_BYTES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),    // in_byte, record_first, record_len, read_max, sender_accepts
        .s_tuser(s_tuser),    // mode
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),    // out_byte, fill_level, free_bytes, busy_res
        .m_tuser(m_tuser),    // status, byte_valid
        .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    fifo_req_t  req_backlog[$];
    fifo_beat_t expected_beats[$];

    // behavioral ring state
    logic [BYTE_W-1:0] ring_mem [RING_BYTES];
    int  wr_idx, rd_idx;
    bit  tx_busy;
    int  rec_left;
    bit  rec_drop;

    int  queued_reqs, accepted_reqs, checked_beats, error_count;
    int  peak_level, wr_wraps, drained_bytes;

    function automatic int ring_level();
        return (wr_idx + RING_BYTES - rd_idx) % RING_BYTES;
    endfunction

    function automatic int ring_room();
        return RING_BYTES - ring_level() - 1;
    endfunction

    function automatic void push_beat(logic [STAT_W-1:0] status, logic [BYTE_W-1:0] data,
                                      logic valid, logic last);
        fifo_beat_t b;
        b.status = status;
        b.data   = data;
        b.valid  = valid;
        b.last   = last;
        b.level  = LVL_W'(ring_level());
        b.room   = LVL_W'(ring_room());
        b.busy   = tx_busy;
        expected_beats.push_back(b);
    endfunction

    // record admission for one written byte
    function automatic logic [STAT_W-1:0] admit_byte(fifo_req_t r);
        if (r.first) begin
            rec_left = 0;
            rec_drop = 0;
            if (r.len == 0) return STAT_BADLEN;
            rec_left = int'(r.len) - 1;
            if (int'(r.len) > ring_room()) begin
                rec_drop = 1;
                return STAT_FULL;
            end
        end else begin
            if (rec_left == 0) return STAT_BADLEN;
            rec_left--;
            if (rec_drop) return STAT_FULL;
            if (ring_room() == 0) return STAT_FULL;
        end
        ring_mem[wr_idx] = r.data;
        wr_idx = (wr_idx + 1) % RING_BYTES;
        if (wr_idx == 0) wr_wraps++;
        if (ring_level() > peak_level) peak_level = ring_level();
        return STAT_OK;
    endfunction

    // pops n bytes, then emits one beat per byte with the post-step level
    function automatic void pop_and_emit(int n);
        logic [BYTE_W-1:0] taken[$];
        for (int i = 0; i < n; i++) begin
            taken.push_back(ring_mem[rd_idx]);
            rd_idx = (rd_idx + 1) % RING_BYTES;
        end
        for (int i = 0; i < n; i++)
            push_beat(STAT_OK, taken[i], 1'b1, i == n - 1);
    endfunction

    // predicted result beats for one accepted request
    function automatic void ring_predict(fifo_req_t r);
        int n;
        case (r.mode)
            MODE_WRITE: begin
                push_beat(admit_byte(r), '0, 1'b0, 1'b1);
            end
            MODE_READ: begin
                if (ring_level() == 0) begin
                    push_beat(STAT_EMPTY, '0, 1'b0, 1'b1);
                end else begin
                    n = int'(r.rmax);
                    if (n > MAX_READ) n = MAX_READ;
                    if (n > ring_level()) n = ring_level();
                    if (n == 0) push_beat(STAT_OK, '0, 1'b0, 1'b1);
                    else pop_and_emit(n);
                end
            end
            MODE_START: begin
                if (tx_busy) begin
                    push_beat(STAT_BUSY, '0, 1'b0, 1'b1);
                end else if (ring_level() == 0) begin
                    push_beat(STAT_EMPTY, '0, 1'b0, 1'b1);
                end else if (!r.accepts) begin
                    push_beat(STAT_REFUSED, '0, 1'b0, 1'b1);
                end else begin
                    // contiguous run up to the write pointer or the end of the store
                    n = (wr_idx > rd_idx) ? wr_idx - rd_idx : RING_BYTES - rd_idx;
                    if (n > BLOCK_BYTES) n = BLOCK_BYTES;
                    tx_busy = 1;
                    drained_bytes += n;
                    pop_and_emit(n);
                end
            end
            MODE_DONE: begin
                tx_busy = 0;
                push_beat(STAT_OK, '0, 1'b0, 1'b1);
            end
            MODE_CLEAR: begin
                wr_idx = 0;
                rd_idx = 0;
                push_beat(STAT_OK, '0, 1'b0, 1'b1);
            end
            default: begin
                push_beat(STAT_OK, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------
    // unused fields carry random values so that every bit toggles
    function automatic fifo_req_t rand_req(logic [MODE_W-1:0] mode);
        fifo_req_t r;
        r.mode    = mode;
        r.data    = BYTE_W'($urandom_range(0, 255));
        r.first   = 1'($urandom_range(0, 1));
        r.len     = LEN_W'($urandom_range(0, 1023));
        r.rmax    = RMAX_W'($urandom_range(0, 127));
        r.accepts = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic void add_req(fifo_req_t r);
        req_backlog.push_back(r);
        queued_reqs++;
    endfunction

    function automatic void add_write(logic first, int len, int data);
        fifo_req_t r;
        r = rand_req(MODE_WRITE);
        r.first = first;
        r.len   = LEN_W'(len);
        r.data  = BYTE_W'(data);
        add_req(r);
    endfunction

    // header byte with length len, then sent-1 body bytes
    function automatic void add_record(int len, int sent);
        add_write(1'b1, len, $urandom_range(0, 255));
        for (int i = 1; i < sent; i++)
            add_write(1'b0, $urandom_range(0, 1023), $urandom_range(0, 255));
    endfunction

    function automatic void add_read(int rmax);
        fifo_req_t r;
        r = rand_req(MODE_READ);
        r.rmax = RMAX_W'(rmax);
        add_req(r);
    endfunction

    function automatic void add_start(logic accepts);
        fifo_req_t r;
        r = rand_req(MODE_START);
        r.accepts = accepts;
        add_req(r);
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of random length with random gaps
    // ------------------------------------------------------------------
    fifo_req_t cur_req;
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                ring_predict(cur_req);
                accepted_reqs++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    cur_req = req_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, cur_req.accepts, cur_req.rmax, cur_req.len,
                                 cur_req.first, cur_req.data};
                    s_tuser  <= cur_req.mode;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and result-side stall pattern
    // ------------------------------------------------------------------
    int cycle_count = 0;

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $realtime, checked_beats, field, got, want);
        error_count++;
    endtask

    task automatic check_beat();
        fifo_beat_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
        end else begin
            want = expected_beats.pop_front();
            if (m_tuser[2:0] !== want.status) report_mismatch("status", m_tuser[2:0], want.status);
            if (m_tuser[3] !== want.valid) report_mismatch("byte_valid", m_tuser[3], want.valid);
            if (m_tdata[7:0] !== want.data) report_mismatch("out_byte", m_tdata[7:0], want.data);
            if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
            if (m_tdata[17:8] !== want.level)
                report_mismatch("fill_level", m_tdata[17:8], want.level);
            if (m_tdata[27:18] !== want.room)
                report_mismatch("free_bytes", m_tdata[27:18], want.room);
            if (m_tdata[28] !== want.busy) report_mismatch("busy_res", m_tdata[28], want.busy);
        end
        checked_beats++;
    endtask

    // four stall styles, taken in turn by cycle count
    function automatic logic pick_ready(int cyc);
        case ((cyc / 256) % 4)
            0:       return 1'b1;
            1:       return (cyc % 4) != 3;
            2:       return 1'($urandom_range(0, 1));
            default: return (cyc % 16) >= 6;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_beat();
            cycle_count++;
            m_tready <= pick_ready(cycle_count);
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles with no handshake on either side
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("record_byte_fifo_with_block_drain_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int pick, len, target;

        wr_idx = 0;
        rd_idx = 0;
        tx_busy = 0;
        rec_left = 0;
        rec_drop = 0;

        // directed corners
        add_read(64);                        // read on empty store
        add_start(1'b1);                     // start on empty store
        add_req(rand_req(MODE_DONE));        // complete while not busy
        add_write(1'b0, 0, 255);             // byte outside any record
        add_write(1'b1, 0, 0);               // zero record length
        add_write(1'b1, 3, 0);
        add_write(1'b0, 1023, 255);
        add_write(1'b0, 0, 8'hA5);
        add_read(0);                         // read_max zero
        add_start(1'b0);                     // refused by the sender
        add_start(1'b1);                     // drains the three bytes
        add_start(1'b1);                     // busy
        add_req(rand_req(MODE_DONE));
        add_write(1'b1, 1023, 8'h5A);        // longest record that fits, left open
        add_record(2, 2);                    // new header ends the open record
        add_record(1023, 3);                 // too long: header and body dropped
        add_record(2, 2);
        add_read(127);                       // read_max above the cap
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            add_req(rand_req(MODE_W'(m)));   // unused modes
        add_record(4, 4);
        add_req(rand_req(MODE_CLEAR));
        add_read(64);                        // empty after clear

        // random mix of mostly well-formed traffic
        target = queued_reqs + RANDOM_ITEMS;
        while (queued_reqs < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                add_record(len, len);
            end else if (pick < 60) begin
                case ($urandom_range(0, 6))
                    0:       add_read(0);
                    1:       add_read($urandom_range(65, 127));
                    default: add_read($urandom_range(1, 64));
                endcase
            end else if (pick < 75) begin
                add_start($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 9) < 7) add_req(rand_req(MODE_DONE));
            end else if (pick < 80) begin
                add_req(rand_req(MODE_DONE));
            end else if (pick < 83) begin
                add_req(rand_req(MODE_CLEAR));
            end else if (pick < 95) begin
                // broken record sequences
                case ($urandom_range(0, 3))
                    0: add_write(1'b1, 0, $urandom_range(0, 255));
                    1: begin
                        len = $urandom_range(3, 20);
                        add_record(len, $urandom_range(1, len - 1));
                    end
                    2: add_write(1'b0, $urandom_range(0, 1023), $urandom_range(0, 255));
                    default: begin
                        len = $urandom_range(512, 1023);
                        add_record(len, $urandom_range(1, 6));
                    end
                endcase
            end else begin
                add_req(rand_req(MODE_W'($urandom_range(0, 7))));
            end
        end

        // refill from a cleared store, then drain by reads and block starts
        add_req(rand_req(MODE_CLEAR));
        repeat (3) add_record(12, 12);
        add_record(5, 5);
        repeat (2) add_read(64);
        repeat (3) add_record(1, 1);
        repeat (3) begin
            add_start(1'b1);
            add_req(rand_req(MODE_DONE));
        end
        add_read(64);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_backlog.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (expected_beats.size() != 0) report_mismatch("beats never returned",
                                                        0, expected_beats.size());
        $display("run covered %0d requests and %0d result beats, %0d bytes sent by block start",
                 accepted_reqs, checked_beats, drained_bytes);
        $display("peak fill level %0d, write pointer wrapped %0d times, %0d mismatches",
                 peak_level, wr_wraps, error_count);
        if (error_count == 0) begin
            $display("record_byte_fifo_with_block_drain_core: match");
        end else begin
            $display("record_byte_fifo_with_block_drain_core: mismatch");
        end
        $finish;
    end

endmodule
